@@ hdl/paged_bump_allocator_freeze_recycle_defines.svh @@
// Assertion macros for the paged bump allocator.
// Included by every file that carries concurrent checks; no other dependency.
`ifndef PAGED_BUMP_ALLOCATOR_FREEZE_RECYCLE_DEFINES_SVH
`define PAGED_BUMP_ALLOCATOR_FREEZE_RECYCLE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, idle during reset.
`define PBAFR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in %m");
// Next-cycle implication, idle during reset.
`define PBAFR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in %m");
`else
`define PBAFR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PBAFR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/pbafr_pkg.sv @@
// Shared types and constants of the paged bump allocator.
// Used by the controller, the datapath and the top level.
package pbafr_pkg;

    localparam int PAGE_BITS_DEF = 12;
    localparam int NUM_PAGES_DEF = 256;

    localparam int LEN_W   = 13;
    localparam int OFF_W   = 20;
    localparam int STAMP_W = 32;
    localparam int CNT_W   = 13;

    localparam logic [CNT_W-1:0]   COUNT_MAX   = '1;
    localparam logic [STAMP_W-1:0] GRACE_RESET = STAMP_W'(1);

    typedef logic [STAMP_W-1:0] t_grace;

    typedef struct packed {
        logic             action;
        logic [LEN_W-1:0] alloc_length;
        logic [OFF_W-1:0] free_offset;
        logic [STAMP_W-1:0] now_stamp;
    } t_req;

    typedef struct packed {
        logic [OFF_W-1:0] value_offset;
        logic             status;
    } t_rsp;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Micro-operations the controller hands to the datapath, one per cycle.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_SET_STATUS,
        OP_RD_CNT_PAGE,
        OP_FREE_DEC,
        OP_RD_LINK_NEWEST,
        OP_OLDEST,
        OP_UNLINK,
        OP_RELINK,
        OP_RD_CNT_CUR,
        OP_BUMP,
        OP_FRZ_SELF,
        OP_FRZ_LINK,
        OP_FRZ_NEWEST,
        OP_RD_LINK_HEAD,
        OP_TAKE,
        OP_LOAD_OUT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic in_ready;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic is_free;
        logic page_ok;
        logic too_long;
        logic newest_valid;
        logic link_valid;
        logic aged;
        logic cnt_zero;
        logic cnt_one;
        logic page_current;
        logic fits;
        logic head_valid;
        logic bump_nonzero;
        logic out_free;
    } t_stat;

endpackage

@@ hdl/pbafr_chan_if.sv @@
// Valid/ready channel carrying one payload per beat.
// Payload type is set per instance; typically a pbafr_pkg struct.
interface pbafr_chan_if #(
    parameter type t_data = logic
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/pbafr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the page tables of the allocator datapath.
module pbafr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ hdl/pbafr_ctrl.sv @@
// Sequencer of the allocator: walks free, recycle, bump, freeze and take steps.
// Depends on pbafr_pkg for the command and status types.
`include "paged_bump_allocator_freeze_recycle_defines.svh"
module pbafr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pbafr_pkg::t_stat i_stat,
    output pbafr_pkg::t_cmd  o_cmd
);
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_F_CHK,
        ST_R_OLD,
        ST_R_STAMP,
        ST_R_RELINK,
        ST_PLACE,
        ST_BUMP,
        ST_NP_CHK,
        ST_FRZ0,
        ST_FRZ1,
        ST_FRZ2,
        ST_TAKE,
        ST_TAKE2,
        ST_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_ret_take, n_ret_take;

    always_comb begin
        n_state      = r_state;
        n_ret_take   = r_ret_take;
        o_cmd.op     = pbafr_pkg::OP_NONE;
        o_cmd.in_ready = (r_state == ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_stat.in_valid) begin
                    o_cmd.op = pbafr_pkg::OP_LATCH;
                    n_state  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (i_stat.is_free) begin
                    if (i_stat.page_ok) begin
                        o_cmd.op = pbafr_pkg::OP_RD_CNT_PAGE;
                        n_state  = ST_F_CHK;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end else if (i_stat.too_long) begin
                    o_cmd.op = pbafr_pkg::OP_SET_STATUS;
                    n_state  = ST_FINISH;
                end else if (i_stat.newest_valid) begin
                    o_cmd.op = pbafr_pkg::OP_RD_LINK_NEWEST;
                    n_state  = ST_R_OLD;
                end else begin
                    n_state = ST_PLACE;
                end
            end
            ST_F_CHK: begin
                if (i_stat.cnt_zero) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.op = pbafr_pkg::OP_FREE_DEC;
                    // last value gone from a page that is not being bumped: freeze it
                    if (i_stat.cnt_one && !i_stat.page_current) begin
                        n_ret_take = 1'b0;
                        n_state    = ST_FRZ0;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_R_OLD: begin
                if (i_stat.link_valid) begin
                    o_cmd.op = pbafr_pkg::OP_OLDEST;
                    n_state  = ST_R_STAMP;
                end else begin
                    n_state = ST_PLACE;
                end
            end
            ST_R_STAMP: begin
                if (i_stat.aged) begin
                    o_cmd.op = pbafr_pkg::OP_UNLINK;
                    n_state  = ST_R_RELINK;
                end else begin
                    n_state = ST_PLACE;
                end
            end
            ST_R_RELINK: begin
                o_cmd.op = pbafr_pkg::OP_RELINK;
                n_state  = ST_PLACE;
            end
            ST_PLACE: begin
                if (i_stat.fits) begin
                    o_cmd.op = pbafr_pkg::OP_RD_CNT_CUR;
                    n_state  = ST_BUMP;
                end else if (!i_stat.head_valid) begin
                    o_cmd.op = pbafr_pkg::OP_SET_STATUS;
                    n_state  = ST_FINISH;
                end else if (i_stat.bump_nonzero) begin
                    o_cmd.op = pbafr_pkg::OP_RD_CNT_CUR;
                    n_state  = ST_NP_CHK;
                end else begin
                    o_cmd.op = pbafr_pkg::OP_RD_LINK_HEAD;
                    n_state  = ST_TAKE2;
                end
            end
            ST_BUMP: begin
                o_cmd.op = pbafr_pkg::OP_BUMP;
                n_state  = ST_FINISH;
            end
            ST_NP_CHK: begin
                if (i_stat.cnt_zero) begin
                    n_ret_take = 1'b1;
                    n_state    = ST_FRZ0;
                end else begin
                    o_cmd.op = pbafr_pkg::OP_RD_LINK_HEAD;
                    n_state  = ST_TAKE2;
                end
            end
            ST_FRZ0: begin
                if (i_stat.newest_valid) begin
                    o_cmd.op = pbafr_pkg::OP_RD_LINK_NEWEST;
                    n_state  = ST_FRZ1;
                end else begin
                    o_cmd.op = pbafr_pkg::OP_FRZ_SELF;
                    n_state  = r_ret_take ? ST_TAKE : ST_FINISH;
                end
            end
            ST_FRZ1: begin
                o_cmd.op = pbafr_pkg::OP_FRZ_LINK;
                n_state  = ST_FRZ2;
            end
            ST_FRZ2: begin
                o_cmd.op = pbafr_pkg::OP_FRZ_NEWEST;
                n_state  = r_ret_take ? ST_TAKE : ST_FINISH;
            end
            ST_TAKE: begin
                o_cmd.op = pbafr_pkg::OP_RD_LINK_HEAD;
                n_state  = ST_TAKE2;
            end
            ST_TAKE2: begin
                o_cmd.op = pbafr_pkg::OP_TAKE;
                n_state  = ST_FINISH;
            end
            ST_FINISH: begin
                // hold the result until the output register can take it
                if (i_stat.out_free) begin
                    o_cmd.op = pbafr_pkg::OP_LOAD_OUT;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_ret_take <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ret_take <= n_ret_take;
        end
    end

    `PBAFR_ASSERT_IMP(a_load_only_when_free, i_clk, i_rst_n, o_cmd.op == pbafr_pkg::OP_LOAD_OUT, i_stat.out_free)
    `PBAFR_ASSERT_IMP(a_refuse_only_alloc, i_clk, i_rst_n, o_cmd.op == pbafr_pkg::OP_SET_STATUS, !i_stat.is_free)
    `PBAFR_ASSERT_IMP(a_latch_on_beat, i_clk, i_rst_n, o_cmd.op == pbafr_pkg::OP_LATCH, i_stat.in_valid && o_cmd.in_ready)
endmodule

@@ hdl/pbafr_dp.sv @@
// Allocator datapath: bump pointer, free chain head, frozen ring and page tables.
// Depends on pbafr_pkg, pbafr_chan_if and pbafr_ram; driven by pbafr_ctrl commands.
`include "paged_bump_allocator_freeze_recycle_defines.svh"
module pbafr_dp #(
    parameter int PAGE_BITS = pbafr_pkg::PAGE_BITS_DEF,
    parameter int NUM_PAGES = pbafr_pkg::NUM_PAGES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    pbafr_chan_if.sink       i_req,
    pbafr_chan_if.source     o_rsp,
    pbafr_chan_if.sink       i_cfg,
    input  pbafr_pkg::t_cmd  i_cmd,
    output pbafr_pkg::t_stat o_stat
);
    // page numbers hold 0..NUM_PAGES plus an all-ones "none" marker
    localparam int PW = $clog2(NUM_PAGES + 2);
    localparam int AW = $clog2(NUM_PAGES);
    localparam int BW = PAGE_BITS + PW;
    localparam int CW = (PAGE_BITS + 1 > pbafr_pkg::LEN_W) ? PAGE_BITS + 1 : pbafr_pkg::LEN_W;
    localparam int XW = (BW > pbafr_pkg::OFF_W) ? BW : pbafr_pkg::OFF_W;
    localparam int OW = pbafr_pkg::OFF_W;
    localparam int SW = pbafr_pkg::STAMP_W;
    localparam int NW = pbafr_pkg::CNT_W;

    localparam logic [PW-1:0] LINK_NONE = '1;
    localparam logic [PW-1:0] NUM_PG    = PW'(NUM_PAGES);
    localparam logic [CW-1:0] PAGE_SZ   = CW'(1) << PAGE_BITS;

    // control state
    logic [SW-1:0] r_grace;
    logic [BW-1:0] r_bump;
    logic [PW-1:0] r_head;
    logic [PW-1:0] r_newest;
    logic [PW-1:0] r_frontier;
    logic          r_out_valid;

    // per-item payload
    logic [pbafr_pkg::LEN_W-1:0] r_len;
    logic                        r_is_free;
    logic                        r_page_ok;
    logic [PW-1:0]               r_page;
    logic [SW-1:0]               r_now;
    logic [PW-1:0]               r_oldest;
    logic [PW-1:0]               r_cur;
    logic                        r_fresh;
    logic [OW-1:0]               r_res_offset;
    logic                        r_res_status;
    pbafr_pkg::t_rsp             r_out_data;

    // table ports
    logic          cnt_we, cnt_re, link_we, link_re, stamp_we, stamp_re;
    logic [AW-1:0] cnt_waddr, cnt_raddr, link_waddr, link_raddr, stamp_waddr, stamp_raddr;
    logic [NW-1:0] cnt_wdata, cnt_rd;
    logic [PW-1:0] link_wdata, link_rd;
    logic [SW-1:0] stamp_wdata, stamp_rd;

    logic [BW-1:0]               bump_m1;
    logic [PW-1:0]               cur_pg;
    logic [PAGE_BITS-1:0]        room;
    logic [CW-1:0]               left;
    logic [PW-1:0]               link_eff;
    logic [BW-1:0]               take_off;
    logic [XW-1:0]               bump_x;
    logic [XW-1:0]               take_x;
    logic [OW-1:0]               free_pg_full;
    logic [pbafr_pkg::LEN_W-1:0] len_fix;

    assign bump_m1  = r_bump - BW'(1);
    assign cur_pg   = bump_m1[BW-1:PAGE_BITS];
    // room left in the current page; zero when there is no current page
    assign room     = ~bump_m1[PAGE_BITS-1:0];
    assign left     = CW'(room);
    assign link_eff = r_fresh ? LINK_NONE : link_rd;
    assign take_off = BW'(r_head) << PAGE_BITS;
    assign bump_x   = XW'(r_bump);
    assign take_x   = XW'(take_off);
    assign free_pg_full = i_req.data.free_offset >> PAGE_BITS;
    assign len_fix  = (i_req.data.alloc_length == '0) ? pbafr_pkg::LEN_W'(1)
                                                      : i_req.data.alloc_length;

    assign i_req.ready = i_cmd.in_ready;
    assign i_cfg.ready = 1'b1;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out_data;

    always_comb begin
        o_stat.in_valid     = i_req.valid;
        o_stat.is_free      = r_is_free;
        o_stat.page_ok      = r_page_ok;
        o_stat.too_long     = CW'(r_len) > PAGE_SZ;
        o_stat.newest_valid = r_newest < NUM_PG;
        o_stat.link_valid   = link_rd < NUM_PG;
        o_stat.aged         = (r_now - stamp_rd) >= r_grace;
        o_stat.cnt_zero     = cnt_rd == '0;
        o_stat.cnt_one      = cnt_rd == NW'(1);
        o_stat.page_current = (r_bump != '0) && (cur_pg == r_page);
        o_stat.fits         = CW'(r_len) <= left;
        o_stat.head_valid   = r_head < NUM_PG;
        o_stat.bump_nonzero = r_bump != '0;
        o_stat.out_free     = !r_out_valid || o_rsp.ready;
    end

    always_comb begin
        cnt_we      = 1'b0;
        cnt_re      = 1'b0;
        cnt_waddr   = AW'(r_cur);
        cnt_raddr   = AW'(r_cur);
        cnt_wdata   = cnt_rd;
        link_we     = 1'b0;
        link_re     = 1'b0;
        link_waddr  = AW'(r_cur);
        link_raddr  = AW'(r_newest);
        link_wdata  = link_rd;
        stamp_we    = 1'b0;
        stamp_re    = 1'b0;
        stamp_waddr = AW'(r_cur);
        stamp_raddr = AW'(link_rd);
        stamp_wdata = r_now;
        case (i_cmd.op)
            pbafr_pkg::OP_RD_CNT_PAGE: begin
                cnt_re    = 1'b1;
                cnt_raddr = AW'(r_page);
            end
            pbafr_pkg::OP_RD_CNT_CUR: begin
                cnt_re    = 1'b1;
                cnt_raddr = AW'(cur_pg);
            end
            pbafr_pkg::OP_FREE_DEC: begin
                cnt_we    = 1'b1;
                cnt_waddr = AW'(r_page);
                cnt_wdata = cnt_rd - NW'(1);
            end
            pbafr_pkg::OP_BUMP: begin
                cnt_we    = 1'b1;
                cnt_wdata = (cnt_rd != pbafr_pkg::COUNT_MAX) ? cnt_rd + NW'(1) : cnt_rd;
            end
            pbafr_pkg::OP_TAKE: begin
                cnt_we    = 1'b1;
                cnt_waddr = AW'(r_head);
                cnt_wdata = NW'(1);
            end
            pbafr_pkg::OP_RD_LINK_NEWEST: begin
                link_re = 1'b1;
            end
            pbafr_pkg::OP_OLDEST: begin
                link_re    = 1'b1;
                link_raddr = AW'(link_rd);
                stamp_re   = 1'b1;
            end
            pbafr_pkg::OP_RD_LINK_HEAD: begin
                link_re    = 1'b1;
                link_raddr = AW'(r_head);
            end
            pbafr_pkg::OP_UNLINK: begin
                link_we    = 1'b1;
                link_waddr = AW'(r_newest);
            end
            pbafr_pkg::OP_RELINK: begin
                link_we    = 1'b1;
                link_waddr = AW'(r_oldest);
                link_wdata = r_head;
            end
            pbafr_pkg::OP_FRZ_SELF: begin
                link_we    = 1'b1;
                link_wdata = r_cur;
                stamp_we   = 1'b1;
            end
            pbafr_pkg::OP_FRZ_LINK: begin
                link_we  = 1'b1;
                stamp_we = 1'b1;
            end
            pbafr_pkg::OP_FRZ_NEWEST: begin
                link_we    = 1'b1;
                link_waddr = AW'(r_newest);
                link_wdata = r_cur;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grace     <= pbafr_pkg::GRACE_RESET;
            r_bump      <= '0;
            r_head      <= '0;
            r_newest    <= LINK_NONE;
            r_frontier  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_grace <= i_cfg.data;
            end
            if (i_cmd.op == pbafr_pkg::OP_LOAD_OUT) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                pbafr_pkg::OP_RELINK: begin
                    r_head <= r_oldest;
                    if (r_oldest == r_newest) begin
                        r_newest <= LINK_NONE;
                    end
                end
                pbafr_pkg::OP_BUMP: begin
                    r_bump <= r_bump + BW'(r_len);
                end
                pbafr_pkg::OP_FRZ_SELF, pbafr_pkg::OP_FRZ_NEWEST: begin
                    r_newest <= r_cur;
                end
                pbafr_pkg::OP_TAKE: begin
                    r_bump <= take_off + BW'(r_len);
                    // a never-linked page hands the head on to the next page
                    r_head <= (link_eff != LINK_NONE) ? link_eff : r_head + PW'(1);
                    if (r_fresh) begin
                        r_frontier <= r_head + PW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            pbafr_pkg::OP_LATCH: begin
                r_is_free    <= i_req.data.action == pbafr_pkg::ACT_FREE;
                r_len        <= len_fix;
                r_page_ok    <= 32'(free_pg_full) < 32'(NUM_PAGES);
                r_page       <= PW'(free_pg_full);
                r_now        <= i_req.data.now_stamp;
                r_res_offset <= '0;
                r_res_status <= 1'b0;
            end
            pbafr_pkg::OP_SET_STATUS: begin
                r_res_status <= 1'b1;
            end
            pbafr_pkg::OP_FREE_DEC: begin
                r_cur <= r_page;
            end
            pbafr_pkg::OP_RD_CNT_CUR: begin
                r_cur <= cur_pg;
            end
            pbafr_pkg::OP_OLDEST: begin
                r_oldest <= link_rd;
            end
            pbafr_pkg::OP_RD_LINK_HEAD: begin
                // pages at or past the frontier were never linked
                r_fresh <= r_head >= r_frontier;
            end
            pbafr_pkg::OP_BUMP: begin
                r_res_offset <= bump_x[OW-1:0];
            end
            pbafr_pkg::OP_TAKE: begin
                r_res_offset <= take_x[OW-1:0];
            end
            pbafr_pkg::OP_LOAD_OUT: begin
                r_out_data.value_offset <= r_res_offset;
                r_out_data.status       <= r_res_status;
            end
            default: begin
            end
        endcase
    end

    pbafr_ram #(.WIDTH(NW), .DEPTH(NUM_PAGES)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (cnt_re),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rd)
    );

    pbafr_ram #(.WIDTH(PW), .DEPTH(NUM_PAGES)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (link_re),
        .i_raddr (link_raddr),
        .o_rdata (link_rd)
    );

    pbafr_ram #(.WIDTH(SW), .DEPTH(NUM_PAGES)) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (stamp_we),
        .i_waddr (stamp_waddr),
        .i_wdata (stamp_wdata),
        .i_re    (stamp_re),
        .i_raddr (stamp_raddr),
        .o_rdata (stamp_rd)
    );

    `PBAFR_ASSERT_IMP(a_frontier_bound, i_clk, i_rst_n, 1'b1, r_frontier <= NUM_PG)
    `PBAFR_ASSERT_NXT(a_take_sets_bump, i_clk, i_rst_n, i_cmd.op == pbafr_pkg::OP_TAKE, r_bump != '0)
    `PBAFR_ASSERT_IMP(a_refused_zero, i_clk, i_rst_n, o_rsp.valid && o_rsp.data.status, o_rsp.data.value_offset == '0)
endmodule

@@ hdl/paged_bump_allocator_freeze_recycle.sv @@
// Paged bump allocator with freeze-and-recycle; controller plus datapath.
// Requests are taken one at a time: a new request is accepted only once the last
// result is in the output register; the page tables take one read and one
// write per cycle and each item walks its table reads and writes in order.
// Reset is synchronous and active low; no table sweep, grace_ticks = 1.
module paged_bump_allocator_freeze_recycle #(
    parameter int PAGE_BITS = pbafr_pkg::PAGE_BITS_DEF,
    parameter int NUM_PAGES = pbafr_pkg::NUM_PAGES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pbafr_chan_if.sink   i_req,
    pbafr_chan_if.source o_rsp,
    pbafr_chan_if.sink   i_cfg
);
    pbafr_pkg::t_cmd  cmd;
    pbafr_pkg::t_stat stat;

    pbafr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    pbafr_dp #(
        .PAGE_BITS (PAGE_BITS),
        .NUM_PAGES (NUM_PAGES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cfg   (i_cfg),
        .i_cmd   (cmd),
        .o_stat  (stat)
    );
endmodule
